[sv/pulse_stream_integrity_tracker_assert.svh]
// Assertion macros for the pulse stream integrity tracker checker.
`ifndef PULSE_STREAM_INTEGRITY_TRACKER_ASSERT_SVH
`define PULSE_STREAM_INTEGRITY_TRACKER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PSIT_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define PSIT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

[sv/psit_pkg.sv]
// Package for the pulse stream integrity tracker: widths, codes, types.
`default_nettype none
package psit_pkg;
    localparam int NUM_SOURCES = 16;
    localparam int SLOT_W = 4;
    localparam int IN_W = 264;
    localparam int OUT_W = 120;

    localparam logic [1:0] REQ_RAW = 2'd0;
    localparam logic [1:0] REQ_DECLARE = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] K_REGISTER = 3'd0;
    localparam logic [2:0] K_FORWARD = 3'd1;
    localparam logic [2:0] K_PARTIAL = 3'd2;
    localparam logic [2:0] K_COMPLETE = 3'd3;
    localparam logic [2:0] K_UNREGISTER = 3'd4;
    localparam logic [2:0] K_REJECTED = 3'd5;
    localparam logic [2:0] K_FULL = 3'd6;
    localparam logic [2:0] K_NONE = 3'd7;

    typedef struct packed {
        logic [31:0] tof;
        logic [31:0] intra;
        logic [7:0]  timing;
        logic [15:0] cycle;
        logic [15:0] veto;
        logic [31:0] charge;
        logic [7:0]  flavor;
    } t_inv;

    typedef struct packed {
        t_inv        inv;
        logic [15:0] exp_seq;
        logic [15:0] dup;
        logic [63:0] last_p;
        logic [63:0] act_p;
        logic [31:0] key;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_RAWRD, S_RAWCHK, S_CLOSE_P, S_CLOSE_C, S_FWD, S_SEQ,
        S_END_C, S_WB, S_FL_RD, S_FL_CHK, S_FL_P, S_FL_C, S_FL_U, S_ONE
    } t_state;
endpackage
`default_nettype wire

[sv/pulse_stream_integrity_tracker.sv]
// Top level of the pulse stream integrity tracker.
// Processing: the scan reads slots from 0 up until it finds the id; then come the close,
// new pulse, forward, sequence and end-of-pulse steps that apply, and the write-back; an
// unseen id scans all 16 slots first. A flush visits the slots in turn, up to the last used.
// The block takes one item at a time, in the idle state only; held results stall it.
// Reset (synchronous, active low) clears the valid bits, the controller and the output valid.
`default_nettype none
module pulse_stream_integrity_tracker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata from bit 0: source_id, pulse_id, flavor, pulse_charge, veto_bits,
    // cycle_number, timing_status, intra_pulse_time, tof_offset, packet_seq,
    // end_of_pulse, zero fill
    input  wire logic [psit_pkg::IN_W-1:0] s_axis_tdata,
    // tuser: req_type
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata from bit 0: out_source_id, slot, out_pulse_id, dup_count,
    // duplicate_flag, sawtooth_flag, zero fill
    output logic [psit_pkg::OUT_W-1:0] m_axis_tdata,
    // tuser: kind
    output logic [2:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    // Entry memory: one read port with registered data, one write port.
    psit_pkg::t_entry r_mem [psit_pkg::NUM_SOURCES];
    psit_pkg::t_entry r_rd;
    logic [psit_pkg::SLOT_W-1:0] rd_addr;
    logic we;
    psit_pkg::t_entry wd;
    logic [psit_pkg::SLOT_W-1:0] wa;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[rd_addr];
    end

    logic [psit_pkg::NUM_SOURCES-1:0] r_valid, n_valid;
    psit_pkg::t_state r_st, n_st;
    logic [psit_pkg::SLOT_W-1:0] r_idx, n_idx;     // scan / current slot
    logic [4:0] r_free, n_free;                    // lowest free slot, bit4 = none
    psit_pkg::t_entry r_e, n_e;                    // working copy
    logic r_df, n_df, r_sf, n_sf;
    logic r_any, n_any;                            // flush emitted something

    // held input item
    logic [1:0]  r_req;
    logic [31:0] r_src;
    logic [63:0] r_pid;
    psit_pkg::t_inv r_inv;
    logic [15:0] r_seq;
    logic r_eop;

    // output register
    logic r_ov, n_ov;
    logic [2:0] r_ok, n_ok;
    logic [31:0] r_os, n_os;
    logic [3:0] r_osl, n_osl;
    logic [63:0] r_op, n_op;
    logic [15:0] r_od, n_od;
    logic r_odf, n_odf, r_osf, n_osf, r_ol, n_ol;

    assign s_axis_tready = (r_st == psit_pkg::S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser = r_ok;
    assign m_axis_tlast = r_ol;
    assign m_axis_tdata = {2'b0, r_osf, r_odf, r_od, r_op, r_osl, r_os};

    logic last_idx;
    assign last_idx = (r_idx == 4'(psit_pkg::NUM_SOURCES - 1));
    logic can_emit;
    assign can_emit = !r_ov || m_axis_tready;
    logic inv_same;
    assign inv_same = (r_pid == r_e.act_p) && (r_inv == r_e.inv);

    always_comb begin
        n_st = r_st; n_idx = r_idx; n_free = r_free;
        n_e = r_e; n_df = r_df; n_sf = r_sf; n_any = r_any; n_valid = r_valid;
        n_ov = r_ov && !m_axis_tready;
        n_ok = r_ok; n_os = r_os; n_osl = r_osl; n_op = r_op; n_od = r_od;
        n_odf = r_odf; n_osf = r_osf; n_ol = r_ol;
        rd_addr = r_idx; we = 1'b0; wa = r_idx; wd = r_e;
        case (r_st)
            psit_pkg::S_IDLE: begin
                rd_addr = '0;
                n_idx = '0; n_free = 5'h10; n_any = 1'b0;
                n_df = 1'b0; n_sf = 1'b0;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == psit_pkg::REQ_FLUSH) n_st = psit_pkg::S_FL_RD;
                    else if (s_axis_tuser == psit_pkg::REQ_UNUSED) n_st = psit_pkg::S_ONE;
                    else n_st = psit_pkg::S_SEARCH;
                end
            end
            psit_pkg::S_SEARCH: begin
                // r_rd holds entry r_idx
                if (r_pid == 64'd0) begin
                    if (can_emit) begin
                        n_ov = 1'b1; n_ok = psit_pkg::K_REJECTED; n_os = r_src;
                        n_osl = '0; n_op = '0; n_od = '0; n_odf = 1'b0; n_osf = 1'b0;
                        n_ol = 1'b1; n_st = psit_pkg::S_IDLE;
                    end
                end else if (r_valid[r_idx] && r_rd.key == r_src) begin
                    if (r_req == psit_pkg::REQ_DECLARE) n_st = psit_pkg::S_ONE;
                    else begin
                        n_e = r_rd; n_st = psit_pkg::S_RAWCHK;
                    end
                end else begin
                    if (!r_valid[r_idx] && r_free[4]) n_free = {1'b0, r_idx};
                    if (!last_idx) begin
                        n_idx = r_idx + 4'd1; rd_addr = r_idx + 4'd1;
                    end else if (can_emit) begin
                        n_ov = 1'b1; n_os = r_src; n_od = '0;
                        n_odf = 1'b0; n_osf = 1'b0;
                        if (!r_valid[r_idx] && r_free[4]) n_free = {1'b0, r_idx};
                        if (n_free[4]) begin
                            n_ok = psit_pkg::K_FULL; n_osl = '0; n_op = r_pid;
                            n_ol = 1'b1; n_st = psit_pkg::S_IDLE;
                        end else begin
                            n_ok = psit_pkg::K_REGISTER; n_osl = n_free[3:0];
                            n_op = '0;
                            n_idx = n_free[3:0];
                            n_valid[n_free[3:0]] = 1'b1;
                            n_e = '0; n_e.key = r_src;
                            if (r_req == psit_pkg::REQ_DECLARE) begin
                                n_ol = 1'b1; n_st = psit_pkg::S_WB;
                            end else begin
                                n_ol = 1'b0; n_st = psit_pkg::S_RAWCHK;
                            end
                        end
                    end
                end
            end
            psit_pkg::S_RAWCHK: begin
                if (inv_same) n_st = psit_pkg::S_FWD;
                else if (r_e.act_p != 64'd0) n_st = psit_pkg::S_CLOSE_P;
                else n_st = psit_pkg::S_RAWRD;
            end
            psit_pkg::S_CLOSE_P, psit_pkg::S_CLOSE_C: begin
                if (can_emit) begin
                    n_ov = 1'b1; n_os = r_e.key; n_osl = r_idx; n_op = r_e.act_p;
                    n_od = r_e.dup; n_odf = 1'b0; n_osf = 1'b0; n_ol = 1'b0;
                    if (r_st == psit_pkg::S_CLOSE_P) begin
                        n_ok = psit_pkg::K_PARTIAL; n_st = psit_pkg::S_CLOSE_C;
                    end else begin
                        n_ok = psit_pkg::K_COMPLETE; n_st = psit_pkg::S_RAWRD;
                        n_e.last_p = r_e.act_p; n_e.act_p = '0;
                    end
                end
            end
            psit_pkg::S_RAWRD: begin
                // open new pulse
                n_e.act_p = r_pid;
                if (r_pid == r_e.last_p) begin
                    n_df = 1'b1;
                    if (r_e.dup != 16'hFFFF) n_e.dup = r_e.dup + 16'd1;
                end else n_e.dup = '0;
                n_sf = (r_pid < r_e.last_p);
                n_e.inv = r_inv; n_e.exp_seq = '0;
                n_st = psit_pkg::S_FWD;
            end
            psit_pkg::S_FWD: begin
                if (can_emit) begin
                    n_ov = 1'b1; n_ok = psit_pkg::K_FORWARD; n_os = r_src;
                    n_osl = r_idx; n_op = r_pid; n_od = r_e.dup;
                    n_odf = r_df; n_osf = r_sf;
                    n_ol = (r_seq == r_e.exp_seq) && !r_eop;
                    n_e.exp_seq = r_e.exp_seq + 16'd1;
                    if (r_seq != r_e.exp_seq) n_st = psit_pkg::S_SEQ;
                    else if (r_eop) n_st = psit_pkg::S_END_C;
                    else n_st = psit_pkg::S_WB;
                end
            end
            psit_pkg::S_SEQ: begin
                if (can_emit) begin
                    n_ov = 1'b1; n_ok = psit_pkg::K_PARTIAL; n_os = r_src;
                    n_osl = r_idx; n_op = r_pid; n_od = r_e.dup;
                    n_odf = 1'b0; n_osf = 1'b0; n_ol = !r_eop;
                    n_st = r_eop ? psit_pkg::S_END_C : psit_pkg::S_WB;
                end
            end
            psit_pkg::S_END_C: begin
                if (can_emit) begin
                    n_ov = 1'b1; n_ok = psit_pkg::K_COMPLETE; n_os = r_e.key;
                    n_osl = r_idx; n_op = r_e.act_p; n_od = r_e.dup;
                    n_odf = 1'b0; n_osf = 1'b0; n_ol = 1'b1;
                    n_e.last_p = r_e.act_p; n_e.act_p = '0;
                    n_st = psit_pkg::S_WB;
                end
            end
            psit_pkg::S_WB: begin
                we = 1'b1; n_st = psit_pkg::S_IDLE;
            end
            psit_pkg::S_FL_RD: begin
                // r_rd now holds entry r_idx
                n_e = r_rd;
                n_st = psit_pkg::S_FL_CHK;
            end
            psit_pkg::S_FL_CHK: begin
                if (!r_valid[r_idx]) begin
                    if (last_idx) n_st = r_any ? psit_pkg::S_IDLE : psit_pkg::S_ONE;
                    else begin
                        n_idx = r_idx + 4'd1; rd_addr = r_idx + 4'd1;
                        n_st = psit_pkg::S_FL_RD;
                    end
                end else if (r_e.act_p != 64'd0) n_st = psit_pkg::S_FL_P;
                else n_st = psit_pkg::S_FL_U;
            end
            psit_pkg::S_FL_P, psit_pkg::S_FL_C: begin
                if (can_emit) begin
                    n_ov = 1'b1; n_os = r_e.key; n_osl = r_idx; n_op = r_e.act_p;
                    n_od = r_e.dup; n_odf = 1'b0; n_osf = 1'b0; n_ol = 1'b0;
                    n_any = 1'b1;
                    if (r_st == psit_pkg::S_FL_P) begin
                        n_ok = psit_pkg::K_PARTIAL; n_st = psit_pkg::S_FL_C;
                    end else begin
                        n_ok = psit_pkg::K_COMPLETE; n_st = psit_pkg::S_FL_U;
                    end
                end
            end
            psit_pkg::S_FL_U: begin
                if (can_emit) begin
                    n_ov = 1'b1; n_ok = psit_pkg::K_UNREGISTER; n_os = r_e.key;
                    n_osl = r_idx; n_op = '0; n_od = '0; n_odf = 1'b0; n_osf = 1'b0;
                    n_any = 1'b1;
                    n_valid[r_idx] = 1'b0;
                    // later slots still valid decide whether this is the last result
                    n_ol = ((r_valid >> r_idx) >> 1) == '0;
                    if (last_idx || n_ol) n_st = psit_pkg::S_IDLE;
                    else begin
                        n_idx = r_idx + 4'd1; rd_addr = r_idx + 4'd1;
                        n_st = psit_pkg::S_FL_RD;
                    end
                end
            end
            psit_pkg::S_ONE: begin
                if (can_emit) begin
                    n_ov = 1'b1; n_ok = psit_pkg::K_NONE; n_os = '0; n_osl = '0;
                    n_op = '0; n_od = '0; n_odf = 1'b0; n_osf = 1'b0; n_ol = 1'b1;
                    n_st = psit_pkg::S_IDLE;
                end
            end
            default: n_st = psit_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= psit_pkg::S_IDLE;
            r_valid <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_valid <= n_valid;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_free <= n_free; r_e <= n_e;
        r_df <= n_df; r_sf <= n_sf; r_any <= n_any;
        r_ok <= n_ok; r_os <= n_os; r_osl <= n_osl; r_op <= n_op; r_od <= n_od;
        r_odf <= n_odf; r_osf <= n_osf; r_ol <= n_ol;
        if (s_axis_tvalid && s_axis_tready) begin
            r_req <= s_axis_tuser;
            r_src <= s_axis_tdata[31:0];
            r_pid <= s_axis_tdata[95:32];
            // flavor up to tof_offset, same order as the packed struct
            r_inv <= s_axis_tdata[239:96];
            r_seq <= s_axis_tdata[255:240];
            r_eop <= s_axis_tdata[256];
        end
    end
endmodule
`default_nettype wire

[sv/psit_checker.sv]
// Port-level checker for the pulse stream integrity tracker, with its bind.
`default_nettype none
`include "pulse_stream_integrity_tracker_assert.svh"
module psit_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [2:0] m_axis_tuser,
    input wire logic m_axis_tlast,
    input wire logic [psit_pkg::OUT_W-1:0] m_axis_tdata
);
    logic out_wait, in_take, single_kind, not_fwd, no_flags;
    assign out_wait = m_axis_tvalid && !m_axis_tready;
    assign in_take = s_axis_tvalid && s_axis_tready;
    assign single_kind = m_axis_tvalid && (m_axis_tuser == psit_pkg::K_NONE ||
                         m_axis_tuser == psit_pkg::K_REJECTED ||
                         m_axis_tuser == psit_pkg::K_FULL);
    assign not_fwd = m_axis_tvalid && m_axis_tuser != psit_pkg::K_FORWARD;
    assign no_flags = (m_axis_tdata[117:116] == 2'b00);

    `PSIT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
    `PSIT_ASSERT_IMPL(a_none_last, i_clk, i_rst_n, single_kind, m_axis_tlast)
    `PSIT_ASSERT_NEXT(a_no_accept_after, i_clk, i_rst_n, in_take, !s_axis_tready)
    `PSIT_ASSERT_IMPL(a_flags_fwd, i_clk, i_rst_n, not_fwd, no_flags)
endmodule
bind pulse_stream_integrity_tracker psit_checker u_psit_checker (.*);
`default_nettype wire
